[sv/q16_pkg.sv]
// ----------------------------------------------------------------------------
// Q16 math unit package
// Request and status codes shared by the datapath and the top level.
// ----------------------------------------------------------------------------
package q16_pkg;

    typedef enum logic [2:0] {
        REQ_MUL  = 3'd0,
        REQ_DIV  = 3'd1,
        REQ_ABS  = 3'd2,
        REQ_FLT  = 3'd3,
        REQ_SQRT = 3'd4,
        REQ_CBRT = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DIVZ  = 3'd1,
        ST_QOVF  = 3'd2,
        ST_COVF  = 3'd3,
        ST_NOCNV = 3'd4
    } status_t;

    localparam int unsigned TOL_W = 16;
    localparam int unsigned CAP_W = 8;

    localparam logic [1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [1:0] CFG_ITER_CAP  = 2'd1;

endpackage

[sv/q16_fixed_point_math_unit_top.sv]
// ----------------------------------------------------------------------------
// Q16 fixed-point math unit
// Multiply, divide, absolute, float conversion and Newton roots.
// Multiply, absolute and conversion pass through S_MUL and offer their result in S_OUT;
// the next item is taken once S_OUT sees no output stall and the unit is in S_IDLE.
// Divide goes through S_DIVGO and waits in S_DIVW for the divider before S_OUT.
// A root iteration is one division plus the S_SCALE, S_UPD and S_STEP states;
// a root item takes at most max(1, iteration cap) iterations. One item is in flight.
// Reset (rst_n, asynchronous) clears control and loads tolerance 6, cap 64.
// ----------------------------------------------------------------------------
module q16_fixed_point_math_unit_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] result_value,
    output logic [2:0]  status
);
    import q16_pkg::*;

    localparam int unsigned DW = 32 + FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIVGO, S_DIVW, S_SCALE, S_UPD, S_STEP, S_OUT
    } state_t;

    state_t           state_reg;
    logic [TOL_W-1:0] tol_reg;
    logic [CAP_W-1:0] cap_reg;
    logic [2:0]    op_reg;
    logic [31:0]   a_reg, b_reg, t_reg, r_reg;
    logic [2:0]    st_reg;
    logic [7:0]    n_reg;
    logic [63:0]   prod_reg;
    logic [DW-1:0] dvd_reg;
    logic [31:0]   dvs_reg;
    logic          neg_reg;
    logic          start_reg;
    logic          dv_done;
    logic [DW-1:0] dv_quo;
    logic [31:0]   diff_reg;
    logic [31:0]   dmag_reg;
    logic          dneg_reg;

    q16_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .dividend(dvd_reg),
        .divisor(dvs_reg), .done(dv_done), .quotient(dv_quo)
    );

    // Product shifted right arithmetically.
    logic [31:0] mul_res;
    assign mul_res = prod_reg[FRAC_BITS +: 32];

    // Divide inputs from the chosen numerator and denominator.
    logic [31:0] num, den, ma, mb;
    assign num = a_reg;
    assign den = (op_reg == REQ_DIV) ? b_reg : ((op_reg == REQ_CBRT) ? mul_res : t_reg);
    assign ma  = num[31] ? (32'd0 - num) : num;
    assign mb  = den[31] ? (32'd0 - den) : den;

    // Quotient checks.
    logic        q_ovf;
    logic [31:0] q_sgn;
    assign q_ovf = neg_reg ? (dv_quo > DW'(33'h080000000)) : (dv_quo > DW'(32'h7fffffff));
    assign q_sgn = neg_reg ? (32'd0 - dv_quo[31:0]) : dv_quo[31:0];

    // Newton step. The magnitude of the difference is divided by two with a
    // shift, or by three with a reciprocal multiply, which truncates toward zero.
    logic [31:0] dabs, dquot, dstep;
    logic [63:0] recip3;
    assign dabs   = diff_reg[31] ? (32'd0 - diff_reg) : diff_reg;
    assign recip3 = {32'd0, dabs} * 64'h00000000aaaaaaab;
    assign dquot  = (op_reg == REQ_CBRT) ? {1'b0, recip3[63:33]} : {1'b0, dabs[31:1]};
    assign dstep  = dneg_reg ? (32'd0 - dmag_reg) : dmag_reg;

    // Float conversion.
    logic [7:0]  fex;
    logic [23:0] ffr;
    logic signed [10:0] fe;
    logic [63:0] fm;
    logic [31:0] flow;
    logic        fovf;
    always_comb
    begin
        fex = a_reg[30:23];
        ffr = (fex == 8'd0) ? {1'b0, a_reg[22:0]} : {1'b1, a_reg[22:0]};
        fe  = (fex == 8'd0) ? 11'(signed'(FRAC_BITS) - 149)
                            : 11'(signed'({3'b000, fex}) - 150 + signed'(FRAC_BITS));
        fm   = '0;
        fovf = 1'b0;
        flow = '0;
        if (fe <= 0)
        begin
            flow = (-fe >= 32) ? 32'd0 : 32'({40'd0, ffr} >> (-fe));
        end
        else if (fe >= 40)
        begin
            fovf = (ffr != 24'd0);
        end
        else
        begin
            fm   = {40'd0, ffr} << fe;
            flow = fm[31:0];
            fovf = a_reg[31] ? (fm > 64'h80000000) : (fm > 64'h7fffffff);
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tol_reg   <= 16'd6;
            cap_reg   <= 8'd64;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == CFG_TOLERANCE) tol_reg <= cfg_data;
                if (cfg_index == CFG_ITER_CAP)  cap_reg <= cfg_data[7:0];
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= req_type;
                        a_reg     <= operand_a;
                        b_reg     <= operand_b;
                        t_reg     <= 32'(2) << FRAC_BITS;
                        n_reg     <= '0;
                        st_reg    <= ST_OK;
                        r_reg     <= '0;
                        // The cube root starts from the square of the first estimate.
                        prod_reg  <= 64'(signed'(req_type == REQ_CBRT
                                         ? 32'(2) << FRAC_BITS : operand_a)
                                       * signed'(req_type == REQ_CBRT
                                         ? 32'(2) << FRAC_BITS : operand_b));
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    case (op_reg)
                        REQ_MUL:
                        begin
                            r_reg <= mul_res;
                            state_reg <= S_OUT;
                        end
                        REQ_ABS:
                        begin
                            r_reg <= a_reg[31] ? 32'd0 - a_reg : a_reg;
                            state_reg <= S_OUT;
                        end
                        REQ_FLT:
                        begin
                            if (fex == 8'hff)
                            begin
                                r_reg <= '0;
                                st_reg <= ST_COVF;
                            end
                            else
                            begin
                                r_reg <= a_reg[31] ? 32'd0 - flow : flow;
                                st_reg <= fovf ? ST_COVF : ST_OK;
                            end
                            state_reg <= S_OUT;
                        end
                        REQ_DIV, REQ_SQRT, REQ_CBRT:
                            state_reg <= S_DIVGO;
                        default:
                            state_reg <= S_OUT;
                    endcase
                end
                S_DIVGO:
                begin
                    if (den == 32'd0)
                    begin
                        r_reg <= (op_reg == REQ_DIV) ? 32'd0 : 32'd0;
                        st_reg <= ST_DIVZ;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        dvd_reg   <= {ma, {FRAC_BITS{1'b0}}};
                        dvs_reg   <= mb;
                        neg_reg   <= num[31] ^ den[31];
                        start_reg <= 1'b1;
                        state_reg <= S_DIVW;
                    end
                end
                S_DIVW:
                begin
                    if (dv_done)
                    begin
                        if (op_reg == REQ_DIV)
                        begin
                            r_reg <= q_sgn;
                            st_reg <= q_ovf ? ST_QOVF : ST_OK;
                            state_reg <= S_OUT;
                        end
                        else if (q_ovf)
                        begin
                            r_reg <= t_reg;
                            st_reg <= ST_QOVF;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            diff_reg  <= q_sgn - t_reg;
                            state_reg <= S_SCALE;
                        end
                    end
                end
                S_SCALE:
                begin
                    dmag_reg  <= dquot;
                    dneg_reg  <= diff_reg[31];
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    t_reg <= t_reg + dstep;
                    n_reg <= n_reg + 8'd1;
                    if (dmag_reg <= {16'd0, tol_reg})
                    begin
                        r_reg <= t_reg + dstep;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (n_reg >= ((cap_reg == 8'd0) ? 8'd1 : cap_reg))
                    begin
                        r_reg <= t_reg;
                        st_reg <= ST_NOCNV;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        prod_reg <= 64'(signed'(t_reg) * signed'(t_reg));
                        state_reg <= S_DIVGO;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid    = (state_reg == S_OUT);
    assign result_value = r_reg;
    assign status       = st_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> st_reg <= ST_NOCNV)
        else $error("bad status");
    a_start_wait: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> state_reg == S_DIVW)
        else $error("divider started outside wait");

endmodule

[sv/q16_divider.sv]
// ----------------------------------------------------------------------------
// Q16 shared divider
// Unsigned restoring divider, one quotient bit per cycle, for dividends of
// up to 32+FRAC_BITS bits by a 32-bit divisor.
// ----------------------------------------------------------------------------
module q16_divider #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [32+FRAC_BITS-1:0] dividend,
    input  logic [31:0]             divisor,
    output logic                    done,
    output logic [32+FRAC_BITS-1:0] quotient
);
    localparam int unsigned DW  = 32 + FRAC_BITS;
    localparam int unsigned CW  = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [32:0]   rem_reg;
    logic [31:0]   dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [32:0]   shifted;
    logic [33:0]   diff;

    assign shifted = {rem_reg[31:0], quo_reg[DW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (!diff[33])
                begin
                    rem_reg <= diff[32:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // The remainder always stays below the divisor between steps.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |-> rem_reg < {1'b0, dvs_reg})
        else $error("divider remainder out of range");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule
